### rtl/core/bmm_pkg.sv
// bmm_pkg: shared types and constants of the banked memory map
`timescale 1ns / 1ps

package bmm_pkg;

  localparam int unsigned RamAw   = 15;   // low ram, high ram, basic rom
  localparam int unsigned DiskAw  = 12;   // disk rom
  localparam int unsigned PlaneAw = 14;   // one video plane
  localparam int unsigned NPlanes = 4;

  localparam logic [7:0] BankCtrlReset = 8'h0f;
  localparam int unsigned BankVideoBit = 4;
  localparam int unsigned BankLowRamBit = 5;

  localparam logic [1:0] VideoWinTop = 2'b10;  // address bits 15:14 of 0x8000-0xbfff
  localparam logic [3:0] DiskWinTop  = 4'h6;   // address bits 15:12 of 0x6000-0x6fff

  localparam logic [7:0] RamFill = 8'h00;
  localparam logic [7:0] RomFill = 8'hff;

  typedef enum logic [2:0] {
    MODE_READ      = 3'd0,
    MODE_WRITE     = 3'd1,
    MODE_IO_WRITE  = 3'd2,
    MODE_PORT_SIG  = 3'd3,
    MODE_BASIC_LD  = 3'd4,
    MODE_DISK_LD   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    SRC_VIDEO,
    SRC_HIGH,
    SRC_LOW,
    SRC_DISK,
    SRC_BASIC
  } src_e;

endpackage

### rtl/core/banked_memory_map_with_vram_planes.sv
// banked_memory_map_with_vram_planes: banked cpu memory map with four video planes
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | mode_i, address_i, data_in_i, signal_mask_i
//  out     | source    | out_valid_o/out_ready_i | read_data_o (only for cpu reads)
//
//  one beat is accepted per cycle while in_ready_o is high; every memory has a single synchronous access port
//  a cpu read passes the memory read register, then the plane and bank mux into the output register
//  writes, control updates and rom loads land at the acceptance edge and give no result beat
//  after reset a clearing pass walks every ram address and fills ram and planes with zeros and the roms
//  with 0xff; in_ready_o stays low during it
//  a stalled output holds the read stage, which in turn drops in_ready_o

module banked_memory_map_with_vram_planes (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_in_i,
  input  logic [7:0]  signal_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o
);

  import bmm_pkg::*;

  // clearing pass
  logic               clr_active_q;
  logic [RamAw-1:0]   clr_cnt_q;

  // bank state
  logic [7:0]         bank_q, bank_d;
  logic               dre_q, dre_d;

  // read stage (memory data is registered inside each memory)
  logic               s1_valid_q, s1_valid_d;
  src_e               s1_src_q, s1_src_d;
  logic [NPlanes-1:0] s1_plane_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [7:0]         read_data_q, read_data_d;

  logic in_acc, s1_adv, is_read, video_win;

  // memory port controls
  logic               low_we, high_we, basic_we, disk_we;
  logic [NPlanes-1:0] plane_we;
  logic [NPlanes-1:0] plane_en;
  logic [RamAw-1:0]   ram_waddr, basic_waddr;
  logic [DiskAw-1:0]  disk_waddr;
  logic [PlaneAw-1:0] plane_waddr;
  logic [7:0]         ram_wdata, rom_wdata;

  logic [7:0]         low_rd_q, high_rd_q, basic_rd_q, disk_rd_q;
  logic [7:0]         plane_rd_q [NPlanes];

  // handshake: the read stage moves on when the output register is free or drained
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !clr_active_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_read    = (mode_i == MODE_READ);

  assign video_win  = (address_i[15:14] == VideoWinTop) && bank_q[BankVideoBit];

  // a clear select bit enables its plane
  always_comb begin
    for (int p = 0; p < NPlanes; p++) begin
      plane_en[p] = !bank_q[p];
    end
  end

  // decode of one accepted beat
  always_comb begin
    low_we   = 1'b0;
    high_we  = 1'b0;
    basic_we = 1'b0;
    disk_we  = 1'b0;
    plane_we = '0;
    bank_d   = bank_q;
    dre_d    = dre_q;
    if (in_acc) begin
      unique case (mode_i)
        MODE_READ: begin
        end
        MODE_WRITE: begin
          priority if (video_win) begin
            plane_we = plane_en;
          end else if (address_i[15]) begin
            high_we = 1'b1;
          end else if (bank_q[BankLowRamBit]) begin
            low_we = 1'b1;
          end else begin
            // rom mapped low, write dropped
          end
        end
        MODE_IO_WRITE: dre_d    = data_in_i[0];
        MODE_PORT_SIG: bank_d   = data_in_i & signal_mask_i;
        MODE_BASIC_LD: basic_we = 1'b1;
        MODE_DISK_LD:  disk_we  = 1'b1;
        default: begin
          // unused modes do nothing
        end
      endcase
    end
  end

  // read source, picked at acceptance with the bank state of that moment
  always_comb begin
    priority if (video_win) begin
      s1_src_d = SRC_VIDEO;
    end else if (address_i[15]) begin
      s1_src_d = SRC_HIGH;
    end else if (bank_q[BankLowRamBit]) begin
      s1_src_d = SRC_LOW;
    end else if (dre_q && (address_i[15:12] == DiskWinTop)) begin
      s1_src_d = SRC_DISK;
    end else begin
      s1_src_d = SRC_BASIC;
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_d = is_read;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // write ports are shared with the clearing pass
  always_comb begin
    if (clr_active_q) begin
      ram_waddr   = clr_cnt_q;
      basic_waddr = clr_cnt_q;
      disk_waddr  = clr_cnt_q[DiskAw-1:0];
      plane_waddr = clr_cnt_q[PlaneAw-1:0];
      ram_wdata   = RamFill;
      rom_wdata   = RomFill;
    end else begin
      ram_waddr   = address_i[RamAw-1:0];
      basic_waddr = address_i[RamAw-1:0];
      disk_waddr  = address_i[DiskAw-1:0];
      plane_waddr = address_i[PlaneAw-1:0];
      ram_wdata   = data_in_i;
      rom_wdata   = data_in_i;
    end
  end

  // memories: read only on an accepted read, so the data holds while the stage stalls
  logic [7:0] low_mem   [2**RamAw];
  logic [7:0] high_mem  [2**RamAw];
  logic [7:0] basic_mem [2**RamAw];
  logic [7:0] disk_mem  [2**DiskAw];

  always_ff @(posedge clk_i) begin
    if (low_we || clr_active_q) begin
      low_mem[ram_waddr] <= ram_wdata;
    end
    if (in_acc && is_read) begin
      low_rd_q <= low_mem[address_i[RamAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (high_we || clr_active_q) begin
      high_mem[ram_waddr] <= ram_wdata;
    end
    if (in_acc && is_read) begin
      high_rd_q <= high_mem[address_i[RamAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (basic_we || clr_active_q) begin
      basic_mem[basic_waddr] <= rom_wdata;
    end
    if (in_acc && is_read) begin
      basic_rd_q <= basic_mem[address_i[RamAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (disk_we || clr_active_q) begin
      disk_mem[disk_waddr] <= rom_wdata;
    end
    if (in_acc && is_read) begin
      disk_rd_q <= disk_mem[address_i[DiskAw-1:0]];
    end
  end

  // one 16k array per video plane, all planes share the window offset
  for (genvar gp = 0; gp < NPlanes; gp++) begin : g_plane
    logic [7:0] plane_mem [2**PlaneAw];

    always_ff @(posedge clk_i) begin
      if (plane_we[gp] || clr_active_q) begin
        plane_mem[plane_waddr] <= ram_wdata;
      end
      if (in_acc && is_read) begin
        plane_rd_q[gp] <= plane_mem[address_i[PlaneAw-1:0]];
      end
    end
  end

  // read stage mux: and of the enabled planes, 0xff when none is enabled
  always_comb begin
    logic [7:0] acc;
    acc = 8'hff;
    for (int p = 0; p < NPlanes; p++) begin
      if (s1_plane_q[p]) begin
        acc = acc & plane_rd_q[p];
      end
    end
    unique case (s1_src_q)
      SRC_VIDEO: read_data_d = acc;
      SRC_HIGH:  read_data_d = high_rd_q;
      SRC_LOW:   read_data_d = low_rd_q;
      SRC_DISK:  read_data_d = disk_rd_q;
      SRC_BASIC: read_data_d = basic_rd_q;
      default:   read_data_d = basic_rd_q;
    endcase
  end

  always_comb begin
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      bank_q       <= BankCtrlReset;
      dre_q        <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (clr_active_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          clr_active_q <= 1'b0;
        end
      end
      bank_q      <= bank_d;
      dre_q       <= dre_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && is_read) begin
      s1_src_q   <= s1_src_d;
      s1_plane_q <= plane_en;
    end
    if (s1_adv && s1_valid_q) begin
      read_data_q <= read_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

`ifndef SYNTH
  // nothing enters while the memories are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !in_ready_o)
    else $error("beat accepted during clearing pass");

  // a pending read is not lost while the output stalls
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> s1_valid_q)
    else $error("read stage dropped under stall");

  // only reads produce a result beat
  a_nonread_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_read) |=> !s1_valid_q)
    else $error("non-read beat entered the read stage");

  // bank state leaves the clearing pass at its reset value
  a_bank_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_active_q) |-> (bank_q == BankCtrlReset && !dre_q))
    else $error("bank state changed during clearing pass");
`endif

endmodule

### sim/testbench.sv
// testbench: random and directed check of the banked memory map against a local byte model
`timescale 1ns / 1ps

module testbench;
  import bmm_pkg::*;

  // the two unused modes, which the block must swallow without a beat
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  localparam int RandomBeats = 825;
  localparam int QuietBeats  = 120;   // tail of the run with no idling on either side
  localparam int DrainBeat   = 300;   // random beat before which the sender waits for all reads
  localparam int TailCycles  = 8;

  // one directed stimulus row; fixed marks a read whose byte is typed in here
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  mask;
    logic        fixed;
    logic [7:0]  fixed_byte;
  } stim_row_t;

  localparam int DirectedRows = 25;
  localparam stim_row_t DirectedTable [DirectedRows] = '{
    // fresh after reset: low half is basic rom, upper half is ram, no video window
    '{MODE_READ,     16'h0000, 8'h00, 8'h00, 1'b1, 8'hff},
    '{MODE_READ,     16'hffff, 8'h00, 8'h00, 1'b1, 8'h00},
    '{MODE_READ,     16'h8000, 8'h00, 8'h00, 1'b1, 8'h00},
    // disk rom overlay on, still at its fill value
    '{MODE_IO_WRITE, 16'hffff, 8'h01, 8'h00, 1'b0, 8'h00},
    '{MODE_READ,     16'h6000, 8'h00, 8'h00, 1'b1, 8'hff},
    // rom loads with the offset wrapped to 12 and 15 bits
    '{MODE_DISK_LD,  16'hffff, 8'h5a, 8'h00, 1'b0, 8'h00},
    '{MODE_READ,     16'h6fff, 8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_BASIC_LD, 16'hffff, 8'ha5, 8'h00, 1'b0, 8'h00},
    '{MODE_READ,     16'h7fff, 8'h00, 8'h00, 1'b0, 8'h00},
    // io write keeps only data bit 0, so this turns the overlay off
    '{MODE_IO_WRITE, 16'h0000, 8'hfe, 8'hff, 1'b0, 8'h00},
    '{MODE_READ,     16'h6fff, 8'h00, 8'h00, 1'b0, 8'h00},
    // write to rom space is dropped
    '{MODE_WRITE,    16'h0000, 8'h77, 8'h00, 1'b0, 8'h00},
    '{MODE_READ,     16'h0000, 8'h00, 8'h00, 1'b1, 8'hff},
    // low ram mapped in through the masked port signal
    '{MODE_PORT_SIG, 16'h0000, 8'hff, 8'h20, 1'b0, 8'h00},
    '{MODE_WRITE,    16'h0000, 8'h77, 8'h00, 1'b0, 8'h00},
    '{MODE_READ,     16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
    // video window and low ram together, planes 0 and 2 selected
    '{MODE_PORT_SIG, 16'h0000, 8'hff, 8'h3a, 1'b0, 8'h00},
    '{MODE_WRITE,    16'hbfff, 8'hc3, 8'h00, 1'b0, 8'h00},
    // no plane selected reads all ones
    '{MODE_PORT_SIG, 16'h0000, 8'h1f, 8'hff, 1'b0, 8'h00},
    '{MODE_READ,     16'hbfff, 8'h00, 8'h00, 1'b1, 8'hff},
    // all planes selected: and of written and unwritten planes
    '{MODE_PORT_SIG, 16'h0000, 8'h10, 8'hff, 1'b0, 8'h00},
    '{MODE_READ,     16'hbfff, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ModeSpare6,    16'hffff, 8'hff, 8'hff, 1'b0, 8'h00},
    // window off again, the same address is plain high ram
    '{MODE_PORT_SIG, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_READ,     16'hbfff, 8'h00, 8'h00, 1'b0, 8'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode_q = MODE_READ;
  logic [15:0] addr_q = '0;
  logic [7:0]  data_q = '0;
  logic [7:0]  mask_q = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;

  logic        quiet_phase = 1'b0;
  int          mismatch_count = 0;

  // local copy of the memory map
  logic [7:0]  low_ram_m   [32768];
  logic [7:0]  high_ram_m  [32768];
  logic [7:0]  basic_rom_m [32768];
  logic [7:0]  disk_rom_m  [4096];
  logic [7:0]  vram_m      [65536];
  logic [7:0]  bank_ctrl_m = BankCtrlReset;
  logic        disk_en_m   = 1'b0;

  // bytes that cpu reads still owe, oldest first
  logic [7:0]  read_bytes_q [$];

  banked_memory_map_with_vram_planes dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode_q),
    .address_i     (addr_q),
    .data_in_i     (data_q),
    .signal_mask_i (mask_q),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_o   (read_data)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    foreach (low_ram_m[i]) low_ram_m[i] = RamFill;
    foreach (high_ram_m[i]) high_ram_m[i] = RamFill;
    foreach (basic_rom_m[i]) basic_rom_m[i] = RomFill;
    foreach (disk_rom_m[i]) disk_rom_m[i] = RomFill;
    foreach (vram_m[i]) vram_m[i] = RamFill;
  end

  // cpu view of one address under the current bank setting
  function automatic logic [7:0] map_read(input logic [15:0] a);
    logic [7:0] acc;
    if (a[15:14] == VideoWinTop && bank_ctrl_m[BankVideoBit]) begin
      // a clear select bit puts its plane into the and
      acc = 8'hff;
      for (int p = 0; p < NPlanes; p++) begin
        if (!bank_ctrl_m[p]) acc &= vram_m[p * 16384 + a[13:0]];
      end
      return acc;
    end
    if (a[15]) return high_ram_m[a[14:0]];
    if (bank_ctrl_m[BankLowRamBit]) return low_ram_m[a[14:0]];
    if (disk_en_m && a[15:12] == DiskWinTop) return disk_rom_m[a[11:0]];
    return basic_rom_m[a[14:0]];
  endfunction

  // apply one accepted beat to the local map; reads hand back their byte
  task automatic step_memory_map(input logic [2:0] mode, input logic [15:0] a,
                                 input logic [7:0] d, input logic [7:0] m,
                                 output logic is_read, output logic [7:0] rd);
    is_read = 1'b0;
    rd = 8'h00;
    case (mode)
      MODE_READ: begin
        is_read = 1'b1;
        rd = map_read(a);
      end
      MODE_WRITE: begin
        if (a[15:14] == VideoWinTop && bank_ctrl_m[BankVideoBit]) begin
          for (int p = 0; p < NPlanes; p++) begin
            if (!bank_ctrl_m[p]) vram_m[p * 16384 + a[13:0]] = d;
          end
        end else if (a[15]) begin
          high_ram_m[a[14:0]] = d;
        end else if (bank_ctrl_m[BankLowRamBit]) begin
          low_ram_m[a[14:0]] = d;
        end
        // rom space swallows the write
      end
      MODE_IO_WRITE: disk_en_m = d[0];
      MODE_PORT_SIG: bank_ctrl_m = d & m;
      MODE_BASIC_LD: basic_rom_m[a[14:0]] = d;
      MODE_DISK_LD:  disk_rom_m[a[11:0]] = d;
      default: ;  // spare modes do nothing
    endcase
  endtask

  // present one beat, hold it until accepted, then record what it owes
  task automatic send_beat(input logic [2:0] mode, input logic [15:0] a,
                           input logic [7:0] d, input logic [7:0] m,
                           input logic fixed, input logic [7:0] fixed_byte);
    logic       is_read;
    logic [7:0] rd;
    in_valid <= 1'b1;
    mode_q <= mode;
    addr_q <= a;
    data_q <= d;
    mask_q <= m;
    do @(posedge clk_i); while (!in_ready);
    step_memory_map(mode, a, d, m, is_read, rd);
    if (is_read) read_bytes_q.push_back(fixed ? fixed_byte : rd);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // receiver stalls in bursts, steady ready during the quiet tail
  initial begin
    int   n;
    logic lvl;
    @(posedge clk_i);
    forever begin
      if (quiet_phase) begin
        lvl = 1'b1;
        n = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        lvl = 1'b0;
        n = $urandom_range(1, 12);
      end else begin
        lvl = 1'b1;
        n = $urandom_range(1, 16);
      end
      out_ready <= lvl;
      repeat (n) @(posedge clk_i);
    end
  end

  // every read beat is matched against the oldest owed byte
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) begin
      if (read_bytes_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected read beat: read_data=%02h", read_data);
      end else begin
        if (read_data !== read_bytes_q[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("read_data mismatch: expected %02h, got %02h",
                     read_bytes_q[0], read_data);
        end
        void'(read_bytes_q.pop_front());
      end
    end
  end

  // hard stop; allows for the clearing pass after reset
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [2:0]  mode;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  m;
    int          pick;

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed rows, with gaps thrown in now and then
    for (int i = 0; i < DirectedRows; i++) begin
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 12));
      send_beat(DirectedTable[i].mode, DirectedTable[i].addr, DirectedTable[i].data,
                DirectedTable[i].mask, DirectedTable[i].fixed, DirectedTable[i].fixed_byte);
    end

    for (int i = 0; i < RandomBeats; i++) begin
      if (i == RandomBeats - QuietBeats) quiet_phase = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < 35) mode = MODE_READ;
      else if (pick < 65) mode = MODE_WRITE;
      else if (pick < 75) mode = MODE_PORT_SIG;
      else if (pick < 80) mode = MODE_IO_WRITE;
      else if (pick < 88) mode = MODE_BASIC_LD;
      else if (pick < 95) mode = MODE_DISK_LD;
      else if (pick < 97) mode = ModeSpare6;
      else mode = ModeSpare7;

      // half the addresses fall on a few hot spots per 4k page so reads hit earlier writes
      a = 16'($urandom);
      if ($urandom_range(0, 1)) a[11:2] = '0;
      d = 8'($urandom);
      m = 8'($urandom);
      // open mask half the time so the video window comes up often
      if (mode == MODE_PORT_SIG && $urandom_range(0, 1)) m = 8'hff;

      if (i == DrainBeat) begin
        // hold off until every owed read is back
        while (read_bytes_q.size() != 0) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
        end
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        idle_gap($urandom_range(1, 12));
      end
      send_beat(mode, a, d, m, 1'b0, 8'h00);
    end

    in_valid <= 1'b0;
    while (read_bytes_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bmm_pkg.sv
rtl/core/banked_memory_map_with_vram_planes.sv
sim/testbench.sv
